[rtl/fbfl_pkg.sv]
package fbfl_pkg;

  // fixed field widths
  localparam int IDX_W   = 7;
  localparam int OFS_W   = 15;
  localparam int BB_W    = 8;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  // register map (index = paddr[2])
  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic [BB_W-1:0] BLOCK_BYTES_RST = 8'd10;

  // front end state
  typedef enum logic {
    FE_IDLE,
    FE_POP
  } fe_state_t;

  // result of the allocator front end
  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] index;
  } fe_res_t;

  // word travelling along the offset cells
  typedef struct packed {
    logic             valid;
    logic             status;
    logic [IDX_W-1:0] index;
    logic [OFS_W-1:0] acc;
  } stage_t;

endpackage

[rtl/fbfl_if.sv]
interface fbfl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [fbfl_pkg::IDX_W-1:0]  block_index;

  modport source (output valid, cmd, block_index, input ready);
  modport sink   (input valid, cmd, block_index, output ready);
endinterface

interface fbfl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [fbfl_pkg::IDX_W-1:0]  result_index;
  logic [fbfl_pkg::OFS_W-1:0]  byte_offset;

  modport source (output valid, status, result_index, byte_offset, input ready);
  modport sink   (input valid, status, result_index, byte_offset, output ready);
endinterface

[rtl/fbfl_front.sv]
module fbfl_front #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic                       cmd,
  input  logic [fbfl_pkg::IDX_W-1:0] block_index,
  output logic                       fe_idle,
  output fbfl_pkg::fe_res_t          res
);

  localparam int MEM_DEPTH = (NUM_BLOCKS < 128) ? NUM_BLOCKS : 128;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CW        = $clog2(NUM_BLOCKS + 1);

  fbfl_pkg::fe_state_t state_r, state_nxt;

  logic [fbfl_pkg::IDX_W-1:0] head_r, head_nxt;
  logic                       nonempty_r, nonempty_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              cnt_dec;
  logic [CW+fbfl_pkg::IDX_W-1:0] cnt_ext;

  // link memory: {more below, next lower entry}
  logic [fbfl_pkg::IDX_W:0]   link_mem [MEM_DEPTH];
  logic [fbfl_pkg::IDX_W:0]   rd_r;
  logic                       wr_en;
  logic                       in_range;

  assign cnt_dec  = cnt_r - CW'(1);
  assign cnt_ext  = {{fbfl_pkg::IDX_W{1'b0}}, cnt_dec};
  assign in_range = (32'(block_index) < NUM_BLOCKS);
  assign wr_en    = acc && (cmd == fbfl_pkg::CMD_FREE) && in_range;

  // link memory, read every cycle at the stack top
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[block_index[AW-1:0]] <= {nonempty_r, head_r};
    end
    rd_r <= link_mem[head_r[AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbfl_pkg::FE_IDLE: begin
        if (acc && (cmd == fbfl_pkg::CMD_ALLOC) && nonempty_r) begin
          state_nxt = fbfl_pkg::FE_POP;
        end
      end
      fbfl_pkg::FE_POP: state_nxt = fbfl_pkg::FE_IDLE;
      default:          state_nxt = fbfl_pkg::FE_IDLE;
    endcase
  end

  // outputs and stack/counter update
  always_comb begin
    fe_idle      = (state_r == fbfl_pkg::FE_IDLE);
    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    cnt_nxt      = cnt_r;
    res.status   = fbfl_pkg::ST_DONE;
    res.index    = block_index;
    case (state_r)
      fbfl_pkg::FE_IDLE: begin
        if (cmd == fbfl_pkg::CMD_FREE) begin
          if (acc && in_range) begin
            head_nxt     = block_index;
            nonempty_nxt = 1'b1;
          end
        end else if (nonempty_r) begin
          res.index = head_r;
        end else if (cnt_r != '0) begin
          res.index = cnt_ext[fbfl_pkg::IDX_W-1:0];
          if (acc) begin
            cnt_nxt = cnt_dec;
          end
        end else begin
          res.status = fbfl_pkg::ST_EMPTY;
          res.index  = '0;
        end
      end
      fbfl_pkg::FE_POP: begin
        head_nxt     = rd_r[fbfl_pkg::IDX_W-1:0];
        nonempty_nxt = rd_r[fbfl_pkg::IDX_W];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fbfl_pkg::FE_IDLE;
      head_r     <= '0;
      nonempty_r <= 1'b0;
      cnt_r      <= CW'(NUM_BLOCKS);
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // a pop always returns straight to idle after the link read
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbfl_pkg::FE_POP) |=> (state_r == fbfl_pkg::FE_IDLE))
    else $error("pop wait longer than one cycle");

  // no word taken while the head is being refetched
  a_no_acc_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbfl_pkg::FE_POP) |-> !acc)
    else $error("word accepted during pop");

  // a valid free always leaves the stack non-empty
  a_free_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (nonempty_r && (head_r == $past(block_index))))
    else $error("free did not push");

  // counter moves only on an allocate served by the counter
  a_cnt_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && (cmd == fbfl_pkg::CMD_ALLOC) && !nonempty_r) |=> $stable(cnt_r))
    else $error("counter moved unexpectedly");
`endif

endmodule

[rtl/fbfl_mul_cell.sv]
module fbfl_mul_cell #(
  parameter int BIT = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [fbfl_pkg::BB_W-1:0] block_bytes,
  input  fbfl_pkg::stage_t          prev,
  output fbfl_pkg::stage_t          cur
);

  fbfl_pkg::stage_t            cur_r, cur_nxt;
  logic [fbfl_pkg::OFS_W-1:0]  pp;

  // partial product for this index bit
  assign pp = prev.index[BIT] ? (fbfl_pkg::OFS_W'(block_bytes) << BIT) : '0;

  always_comb begin
    cur_nxt     = prev;
    cur_nxt.acc = prev.acc + pp;
  end

  // valid under reset, payload without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else if (en) begin
      cur_r.valid <= cur_nxt.valid;
    end
    if (en) begin
      cur_r.status <= cur_nxt.status;
      cur_r.index  <= cur_nxt.index;
      cur_r.acc    <= cur_nxt.acc;
    end
  end

  assign cur = cur_r;

endmodule

[rtl/fixed_block_free_list_allocator_unit.sv]
// Fixed-size block pool with a LIFO free list. Each input word is an
// allocate or a free, and each gives exactly one result word: the block
// index (allocated, or the freed one echoed) and its byte offset, index
// times block_bytes. Freed blocks are reused first, most recent first;
// otherwise never-used blocks come out in descending order from
// NUM_BLOCKS-1. An allocate on an exhausted pool returns status 1 with
// index and offset zero. Frees of a double-freed block are not checked.
// A free or a counter allocate keeps the front end idle; an allocate
// served from the freed stack also passes through the pop state, since
// the new stack top comes back registered from the link memory. Results
// pass through the offset cells, one per index bit, and the whole cell
// row holds while the output word is not taken. block_bytes
// (APB register at byte address 0) may be changed only while idle.
module fixed_block_free_list_allocator_unit #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fbfl_in_if.sink                         in_ch,
  fbfl_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbfl_pkg::APB_AW-1:0]     paddr,
  input  logic [fbfl_pkg::APB_DW-1:0]     pwdata,
  output logic [fbfl_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int NCELL = fbfl_pkg::IDX_W;

  logic [fbfl_pkg::BB_W-1:0] block_bytes_r;
  logic                      cfg_wr;
  logic                      fe_idle;
  logic                      acc;
  logic                      en;
  fbfl_pkg::fe_res_t         fe_res;
  fbfl_pkg::stage_t          chain [NCELL+1];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == fbfl_pkg::REG_BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= fbfl_pkg::BLOCK_BYTES_RST;
    end else if (cfg_wr) begin
      block_bytes_r <= pwdata[fbfl_pkg::BB_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == fbfl_pkg::REG_BLOCK_BYTES) begin
      prdata = fbfl_pkg::APB_DW'(block_bytes_r);
    end
  end

  // handshake: cell row advances unless the output word is stuck
  assign en          = !chain[NCELL].valid || out_ch.ready;
  assign in_ch.ready = fe_idle && en;
  assign acc         = in_ch.valid && in_ch.ready;

  fbfl_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .cmd         (in_ch.cmd),
    .block_index (in_ch.block_index),
    .fe_idle     (fe_idle),
    .res         (fe_res)
  );

  // head of the cell row
  always_comb begin
    chain[0].valid  = acc;
    chain[0].status = fe_res.status;
    chain[0].index  = fe_res.index;
    chain[0].acc    = '0;
  end

  // shift-add offset cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    fbfl_mul_cell #(
      .BIT (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .block_bytes (block_bytes_r),
      .prev        (chain[k]),
      .cur         (chain[k+1])
    );
  end

  // last cell is the output register
  assign out_ch.valid        = chain[NCELL].valid;
  assign out_ch.status       = chain[NCELL].status;
  assign out_ch.result_index = chain[NCELL].index;
  assign out_ch.byte_offset  = chain[NCELL].acc;

endmodule

[bench/fixed_block_free_list_allocator_unit_test.sv]
module fixed_block_free_list_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_BLOCKS = 128;
  localparam int SETTLE      = 12;      // extra wait after the last result
  localparam int LIMIT       = 200000;  // watchdog, in clock cycles
  localparam int NPROBE      = 20;

  // pacing of the two sides
  typedef enum int {
    PACE_FREE,
    PACE_SRC,
    PACE_SNK,
    PACE_BOTH
  } pace_t;

  // shape of the free commands
  typedef enum int {
    MIX_CLEAN,   // frees of held blocks, now and then a block nobody holds
    MIX_NOISE    // frees of any block, double frees included
  } mix_t;

  typedef struct packed {
    logic                       status;
    logic [fbfl_pkg::IDX_W-1:0] index;
    logic [fbfl_pkg::OFS_W-1:0] offset;
  } pool_res_t;

  typedef struct packed {
    logic                       cmd;
    logic [fbfl_pkg::IDX_W-1:0] block;
    bit                         typed;
    pool_res_t                  res;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [fbfl_pkg::APB_AW-1:0] paddr;
  logic [fbfl_pkg::APB_DW-1:0] pwdata;
  logic [fbfl_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  fbfl_in_if  in_ch ();
  fbfl_out_if out_ch ();

  fixed_block_free_list_allocator_unit #(
    .NUM_BLOCKS (POOL_BLOCKS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pool mirror
  logic [fbfl_pkg::IDX_W-1:0] next_link [POOL_BLOCKS];
  bit                         next_more [POOL_BLOCKS];
  logic [fbfl_pkg::IDX_W-1:0] stack_top;
  bit                         stack_live;
  int                         fresh_left;
  logic [fbfl_pkg::BB_W-1:0]  bytes_cfg;

  // stimulus bookkeeping
  bit                         stacked [POOL_BLOCKS];
  bit                         held    [POOL_BLOCKS];
  logic [fbfl_pkg::IDX_W-1:0] held_q  [$];

  pool_res_t  pending_q [$];
  int         errors;
  int         src_gap;
  int         stall_pct;
  int         cycles;
  probe_row_t probes [NPROBE];

  function automatic void pool_reset();
    foreach (next_link[k]) begin
      next_link[k] = '0;
      next_more[k] = 1'b0;
      stacked[k]   = 1'b0;
      held[k]      = 1'b0;
    end
    stack_top  = '0;
    stack_live = 1'b0;
    fresh_left = POOL_BLOCKS;
    bytes_cfg  = fbfl_pkg::BLOCK_BYTES_RST;
    held_q.delete();
  endfunction

  function automatic logic [fbfl_pkg::OFS_W-1:0] offset_of(logic [fbfl_pkg::IDX_W-1:0] i);
    return fbfl_pkg::OFS_W'(int'(i) * int'(bytes_cfg));
  endfunction

  // one step of the pool; every index fits the pool, so no range test
  function automatic pool_res_t pool_step(logic c, logic [fbfl_pkg::IDX_W-1:0] b);
    pool_res_t r;
    logic [fbfl_pkg::IDX_W-1:0] top;
    r.status = fbfl_pkg::ST_DONE;
    r.index  = '0;
    if (c == fbfl_pkg::CMD_FREE) begin
      next_link[b] = stack_top;
      next_more[b] = stack_live;
      stack_top    = b;
      stack_live   = 1'b1;
      stacked[b]   = 1'b1;
      r.index      = b;
    end else if (stack_live) begin
      top          = stack_top;
      stack_top    = next_link[top];
      stack_live   = next_more[top];
      stacked[top] = 1'b0;
      r.index      = top;
    end else if (fresh_left > 0) begin
      fresh_left = fresh_left - 1;
      r.index    = fbfl_pkg::IDX_W'(fresh_left);
    end else begin
      r.status = fbfl_pkg::ST_EMPTY;
    end
    r.offset = offset_of(r.index);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // bookkeeping for an accepted word
  task automatic log_accepted(input logic c, input logic [fbfl_pkg::IDX_W-1:0] b,
                              input bit typed, input pool_res_t typed_res);
    pool_res_t r;
    r = pool_step(c, b);
    if (c == fbfl_pkg::CMD_FREE) begin
      if (held[b]) begin
        held[b] = 1'b0;
        foreach (held_q[k]) begin
          if (held_q[k] == b) begin
            held_q.delete(k);
            break;
          end
        end
      end
    end else if (r.status == fbfl_pkg::ST_DONE && !held[r.index]) begin
      held[r.index] = 1'b1;
      held_q.push_back(r.index);
    end
    pending_q.push_back(typed ? typed_res : r);
  endtask

  // present one word, with random gaps in front of it
  task automatic send_word(input logic c, input logic [fbfl_pkg::IDX_W-1:0] b,
                           input bit typed, input pool_res_t typed_res);
    while ($urandom_range(99) < src_gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.block_index <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    log_accepted(c, b, typed, typed_res);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_block_bytes(input logic [fbfl_pkg::BB_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {fbfl_pkg::REG_BLOCK_BYTES, 2'b00};
    pwdata  <= fbfl_pkg::APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    bytes_cfg  = v;
  endtask

  task automatic pick_word(input mix_t mix, input int alloc_pct, output logic c,
                           output logic [fbfl_pkg::IDX_W-1:0] b);
    logic [fbfl_pkg::IDX_W-1:0] cand;
    b = fbfl_pkg::IDX_W'($urandom);
    if ($urandom_range(99) < alloc_pct) begin
      c = fbfl_pkg::CMD_ALLOC;
      return;
    end
    c = fbfl_pkg::CMD_FREE;
    if (mix == MIX_NOISE) return;
    if (held_q.size() > 0 && $urandom_range(9) != 0) begin
      b = held_q[$urandom_range(held_q.size() - 1)];
      return;
    end
    // a block that is neither held nor parked on the stack
    for (int k = 0; k < 8; k++) begin
      cand = fbfl_pkg::IDX_W'($urandom);
      if (!held[cand] && !stacked[cand]) begin
        b = cand;
        return;
      end
    end
    c = fbfl_pkg::CMD_ALLOC;
  endtask

  task automatic run_phase(input int n, input logic [fbfl_pkg::BB_W-1:0] bb,
                           input pace_t pace, input mix_t mix, input int alloc_pct,
                           input int hold_at);
    logic                       c;
    logic [fbfl_pkg::IDX_W-1:0] b;
    wait_all_results();
    write_block_bytes(bb);
    src_gap   = (pace == PACE_SRC) ? 59 : (pace == PACE_BOTH) ? 6 : 0;
    stall_pct = (pace == PACE_SNK) ? 59 : (pace == PACE_BOTH) ? 6 : 0;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) wait_all_results();
      pick_word(mix, alloc_pct, c, b);
      send_word(c, b, 1'b0, '0);
    end
  endtask

  // result side: random stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    pool_res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result word idx %0d with nothing outstanding",
                                  out_ch.result_index));
      end else begin
        w = pending_q.pop_front();
        if (out_ch.status !== w.status)
          report_mismatch($sformatf("status %0b, want %0b", out_ch.status, w.status));
        if (out_ch.result_index !== w.index)
          report_mismatch($sformatf("result_index %0d, want %0d", out_ch.result_index,
                                    w.index));
        if (out_ch.byte_offset !== w.offset)
          report_mismatch($sformatf("byte_offset %0d, want %0d", out_ch.byte_offset,
                                    w.offset));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("fixed_block_free_list_allocator_unit_test: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.cmd         = fbfl_pkg::CMD_ALLOC;
    in_ch.block_index = '0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_n             = 1'b0;
    errors            = 0;
    src_gap           = 0;
    stall_pct         = 0;
    cycles            = 0;
    pool_reset();

    // directed words, block_bytes at its reset value
    probes = '{
      // first from the top
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b1, '{fbfl_pkg::ST_DONE, 7'd127, 15'd1270}},
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b1, '{fbfl_pkg::ST_DONE, 7'd126, 15'd1260}},
      // echoed
      '{fbfl_pkg::CMD_FREE,  7'd127, 1'b1, '{fbfl_pkg::ST_DONE, 7'd127, 15'd1270}},
      // freed block reused first
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b1, '{fbfl_pkg::ST_DONE, 7'd127, 15'd1270}},
      // never allocated
      '{fbfl_pkg::CMD_FREE,  7'd0,   1'b1, '{fbfl_pkg::ST_DONE, 7'd0,   15'd0}},
      '{fbfl_pkg::CMD_FREE,  7'd126, 1'b1, '{fbfl_pkg::ST_DONE, 7'd126, 15'd1260}},
      '{fbfl_pkg::CMD_ALLOC, 7'h7f,  1'b0, '0},   // index ignored on allocate
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'h55,  1'b0, '0},   // stack empty again, back to the counter
      '{fbfl_pkg::CMD_FREE,  7'd125, 1'b0, '0},
      '{fbfl_pkg::CMD_FREE,  7'd0,   1'b0, '0},
      '{fbfl_pkg::CMD_FREE,  7'd127, 1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'h2a,  1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b0, '0},
      '{fbfl_pkg::CMD_FREE,  7'h55,  1'b0, '0},   // never-used blocks, alternating bits
      '{fbfl_pkg::CMD_FREE,  7'h2a,  1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b0, '0},
      '{fbfl_pkg::CMD_ALLOC, 7'd0,   1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[k])
      send_word(probes[k].cmd, probes[k].block, probes[k].typed, probes[k].res);

    // random phases; the first drains the pool so empty results come back
    run_phase(220, 8'd1,   PACE_FREE, MIX_CLEAN, 85, -1);
    run_phase(150, 8'd255, PACE_SRC,  MIX_CLEAN, 45, 75);
    run_phase(150, 8'd0,   PACE_SNK,  MIX_CLEAN, 60, -1);
    run_phase(130, fbfl_pkg::BB_W'($urandom_range(254, 2)), PACE_BOTH, MIX_CLEAN, 50, -1);
    // last: frees of anything, so double frees tie the stack into a loop
    run_phase(130, fbfl_pkg::BB_W'($urandom_range(255, 0)), PACE_BOTH, MIX_NOISE, 50, -1);

    wait_all_results();
    if (errors == 0) begin
      $display("fixed_block_free_list_allocator_unit_test: done, clean");
    end else begin
      $display("fixed_block_free_list_allocator_unit_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fbfl_pkg.sv
rtl/fbfl_if.sv
rtl/fbfl_front.sv
rtl/fbfl_mul_cell.sv
rtl/fixed_block_free_list_allocator_unit.sv
bench/fixed_block_free_list_allocator_unit_test.sv
